>>> rtl/wbss_pkg.sv
// Package: shared types and constants for the wildcard byte signature scanner.
`timescale 1ns / 1ps
package wbss_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int SIG_BYTES   = 16;
  localparam int LEN_W       = 5;
  localparam int OUT_OFS_W   = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_PAT_LO  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_HI  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE    = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_LEN = 4'd3;

  // per-cell compare setup, derived from the signature registers
  typedef struct packed {
    logic [7:0] exp_byte;
    logic       care;
    logic       active;
  } cell_cfg_t;

endpackage

>>> rtl/wbss_cell.sv
// One window cell: holds a byte, passes it on, and compares its incoming byte.
`timescale 1ns / 1ps
module wbss_cell
  import wbss_pkg::*;
(
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] byte_in,
  input  cell_cfg_t  cell_cfg,
  output logic [7:0] byte_out,
  output logic       match
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  assign byte_nxt = shift ? byte_in : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;
  // compare against the byte this cell takes on the current shift
  assign match = !cell_cfg.active || !cell_cfg.care || (byte_in == cell_cfg.exp_byte);

endmodule

>>> rtl/wildcard_byte_signature_scan.sv
// Top level: masked byte signature scanner over a row of window cells.
// A result is registered in the output register or, if that is full, the skid entry.
// Throughput: one byte per cycle while in_ready is high; the cell row shifts and
// compares in the same cycle. A two-entry output buffer keeps bytes flowing while a
// result waits to be taken. Reset (rst_n low, synchronous): registers to 0,0,0,1,
// count and done flag cleared, output buffer empty. No clearing pass.
`timescale 1ns / 1ps
module wildcard_byte_signature_scan
  import wbss_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int OFFSET_BITS       = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_last_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [OUT_OFS_W-1:0]   out_match_offset,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [LEN_W-1:0]       MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);
  localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;

  // configuration registers
  logic [63:0]          pat_lo_r, pat_hi_r;
  logic [SIG_BYTES-1:0] care_r;
  logic [LEN_W-1:0]     pat_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      care_r    <= '0;
      pat_len_r <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAT_LO:  pat_lo_r  <= cfg_data;
        REG_PAT_HI:  pat_hi_r  <= cfg_data;
        REG_CARE:    care_r    <= cfg_data[SIG_BYTES-1:0];
        REG_PAT_LEN: pat_len_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // length in use, clamped to 1..MAX_PATTERN_BYTES
  logic [LEN_W-1:0] len_use;
  always_comb begin
    if (pat_len_r == '0) len_use = LEN_W'(1);
    else if (pat_len_r > MAX_LEN) len_use = MAX_LEN;
    else len_use = pat_len_r;
  end

  logic [8*SIG_BYTES-1:0] sig_all;
  assign sig_all = {pat_hi_r, pat_lo_r};

  // scan state
  logic                   done_r, done_nxt;
  logic [OFFSET_BITS-1:0] seen_r, seen_nxt, seen_inc;
  logic                   accept, shift;

  assign accept = in_valid && in_ready;
  assign shift  = accept && !done_r;

  // cell row: cell k holds window byte k, newest at cell 0
  logic [7:0]                   cell_byte [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_match;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [LEN_W-1:0] sig_idx;
    cell_cfg_t        ccfg;
    logic [7:0]       byte_in;

    // window byte k meets signature byte len-1-k
    assign sig_idx       = len_use - LEN_W'(k) - LEN_W'(1);
    assign ccfg.active   = (LEN_W'(k) < len_use);
    assign ccfg.care     = care_r[sig_idx[3:0]];
    assign ccfg.exp_byte = sig_all[{sig_idx[3:0], 3'b000} +: 8];

    if (k == 0) begin : g_head
      assign byte_in = in_data_byte;
    end else begin : g_body
      assign byte_in = cell_byte[k-1];
    end

    wbss_cell u_cell (
      .clk      (clk),
      .shift    (shift),
      .byte_in  (byte_in),
      .cell_cfg (ccfg),
      .byte_out (cell_byte[k]),
      .match    (cell_match[k])
    );
  end

  logic                   hit, push;
  logic                   res_found;
  logic [OFFSET_BITS-1:0] ofs_full;
  logic [OFFSET_BITS+OUT_OFS_W-1:0] ofs_ext;
  logic [OUT_OFS_W-1:0]   res_ofs;

  assign seen_inc = (seen_r == CNT_MAX) ? seen_r : seen_r + OFFSET_BITS'(1);
  assign hit      = (seen_inc >= OFFSET_BITS'(len_use)) && (&cell_match);
  assign ofs_full = seen_inc - OFFSET_BITS'(len_use);
  assign ofs_ext  = {{OUT_OFS_W{1'b0}}, ofs_full};

  always_comb begin
    seen_nxt  = seen_r;
    done_nxt  = done_r;
    push      = 1'b0;
    res_found = 1'b0;
    res_ofs   = '0;
    if (shift) begin
      seen_nxt = seen_inc;
      if (hit) begin
        push      = 1'b1;
        res_found = 1'b1;
        res_ofs   = ofs_ext[OUT_OFS_W-1:0];
        done_nxt  = 1'b1;
      end else if (in_last_byte) begin
        push = 1'b1;
      end
    end
    if (accept && in_last_byte) begin
      seen_nxt = '0;
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      done_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      done_r <= done_nxt;
    end
  end

  // output register plus skid entry
  logic                 out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic                 out_found_r, out_found_nxt, skid_found_r, skid_found_nxt;
  logic [OUT_OFS_W-1:0] out_ofs_r, out_ofs_nxt, skid_ofs_r, skid_ofs_nxt;
  logic                 pop;

  assign pop      = out_valid_r && out_ready;
  assign in_ready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_ofs_nxt    = out_ofs_r;
    skid_valid_nxt = skid_valid_r;
    skid_found_nxt = skid_found_r;
    skid_ofs_nxt   = skid_ofs_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_found_nxt  = skid_found_r;
        out_ofs_nxt    = skid_ofs_r;
        skid_valid_nxt = push;
        skid_found_nxt = res_found;
        skid_ofs_nxt   = res_ofs;
      end else begin
        out_valid_nxt = push;
        out_found_nxt = res_found;
        out_ofs_nxt   = res_ofs;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_found_nxt = res_found;
      skid_ofs_nxt   = res_ofs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_ofs_r    <= out_ofs_nxt;
    skid_found_r <= skid_found_nxt;
    skid_ofs_r   <= skid_ofs_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_ofs_r;

`ifndef SYNTHESIS
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_not_found_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_offset == '0))
    else $error("not-found result carries a nonzero offset");

  a_rearm : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (!done_r && seen_r == '0))
    else $error("scan not re-armed after final byte");

  a_found_sets_done : assert property (@(posedge clk) disable iff (!rst_n)
    (push && res_found && !in_last_byte) |=> done_r)
    else $error("match did not close the scan");
`endif

endmodule
